>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SBPF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication outside reset.
`define SBPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sbpf_pkg.sv
`default_nettype none

package sbpf_pkg;

  localparam int VIDEO_MEM_BYTES   = 8192;
  localparam int VMEM_AW           = $clog2(VIDEO_MEM_BYTES);
  localparam int DEF_VISIBLE_WIDTH = 160;
  localparam int DEF_VISIBLE_ROWS  = 144;
  localparam int VBLANK_ROWS       = 10;
  localparam int CFG_IDX_W         = 2;

  localparam logic [8:0] SEARCH_TICKS = 9'd80;
  localparam logic [8:0] LINE_TICKS   = 9'd456;
  localparam logic [3:0] QUEUE_SLOTS  = 4'd8;

  localparam logic [1:0]         MAP_PREFIX       = 2'b11;
  localparam logic [VMEM_AW-1:0] SIGNED_TILE_BASE = 13'h0800;
  localparam logic [7:0]         TILE_INDEX_FLIP  = 8'h80;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SELECT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED     = 2'd3;

  localparam logic [2:0] STEP_LOCATE   = 3'd1;
  localparam logic [2:0] STEP_PLANE_LO = 3'd3;
  localparam logic [2:0] STEP_PLANE_HI = 3'd5;
  localparam logic [2:0] STEP_PUSH     = 3'd6;

  localparam logic [1:0] PHC_SEARCH   = 2'd0;
  localparam logic [1:0] PHC_TRANSFER = 2'd1;
  localparam logic [1:0] PHC_HBLANK   = 2'd2;
  localparam logic [1:0] PHC_VBLANK   = 2'd3;

  typedef enum logic [3:0] {
    PH_SEARCH   = 4'b0001,
    PH_TRANSFER = 4'b0010,
    PH_HBLANK   = 4'b0100,
    PH_VBLANK   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    RD_NONE   = 2'd0,
    RD_LOCATE = 2'd1,
    RD_LO     = 2'd2,
    RD_HI     = 2'd3
  } rd_kind_t;

  typedef struct packed {
    logic       pix;
    logic       push;
    rd_kind_t   rd;
    logic [2:0] pop_idx;
    logic [7:0] px;
    logic [7:0] py;
    logic [1:0] phase;
    logic [7:0] row;
  } s1_t;

  function automatic logic [1:0] phase_code(input phase_t p);
    logic [1:0] c;
    case (p)
      PH_SEARCH:   c = PHC_SEARCH;
      PH_TRANSFER: c = PHC_TRANSFER;
      PH_HBLANK:   c = PHC_HBLANK;
      PH_VBLANK:   c = PHC_VBLANK;
      default:     c = PHC_SEARCH;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sbpf_ram.sv
`default_nettype none

module sbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/scanline_background_pixel_fetcher.sv
// Channel  Direction  Payload                                         Handshake
// in       input      command, write_address, write_data              in_valid / in_ready
// out      output     pixel_valid, pixel_x, pixel_y, color_id,        out_valid / out_ready
//                     phase, current_row
// cfg      input      index (0 scroll_y .. 3 signed_tile_mode), data  cfg_valid / cfg_ready
//
// One beat in per cycle while in_ready is high; its result leaves through the video memory
// read and the output register. Every beat makes exactly one result beat.
// After reset the video memory is cleared one byte a cycle, all 8192 bytes, with in_ready low.
// A stalled output holds one result and one more in flight, then in_ready drops.
`default_nettype none

`include "assert_macros.svh"

module scanline_background_pixel_fetcher
  import sbpf_pkg::*;
#(
  parameter int VISIBLE_WIDTH = DEF_VISIBLE_WIDTH,
  parameter int VISIBLE_ROWS  = DEF_VISIBLE_ROWS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_command,
  input  wire logic [VMEM_AW-1:0]   in_write_address,
  input  wire logic [7:0]           in_write_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_pixel_valid,
  output logic [7:0]                out_pixel_x,
  output logic [7:0]                out_pixel_y,
  output logic [1:0]                out_color_id,
  output logic [1:0]                out_phase,
  output logic [7:0]                out_current_row,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int RowW = $clog2(VISIBLE_ROWS + VBLANK_ROWS + 1);
  localparam logic [7:0]      VisWidth = 8'(VISIBLE_WIDTH);
  localparam logic [RowW-1:0] VisRows  = RowW'(VISIBLE_ROWS);
  localparam logic [RowW-1:0] EndRows  = RowW'(VISIBLE_ROWS + VBLANK_ROWS);

  logic [7:0] scroll_y_r, scroll_x_r;
  logic       map_sel_r, signed_mode_r;

  logic               clr_active_r;
  logic [VMEM_AW-1:0] clr_addr_r;

  phase_t            phase_r, phase_nxt;
  logic [8:0]        dot_r, dot_nxt;
  logic [RowW-1:0]   row_r, row_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [3:0]        fill_r, fill_nxt, fill_mid;
  logic [3:0]        rowoff_r, rowoff_nxt;

  logic [VMEM_AW-1:0] tile_base_r;
  logic [7:0]         plane_lo_r, plane_hi_r, q_lo_r, q_hi_r;

  logic s1_valid_r;
  s1_t  s1_r, s1_nxt;

  logic               in_accept, s1_adv;
  logic [7:0]         fx, fy;
  logic [VMEM_AW-1:0] rd_addr, ram_waddr;
  logic [7:0]         ram_wdata, ram_rdata;
  logic               ram_we, ram_re;
  logic [7:0]         src_lo, src_hi;
  logic [1:0]         color;
  logic               push_in_s1, pix_out, pix_phase_ok;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid || out_ready);
  assign in_ready  = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_y_r    <= '0;
      scroll_x_r    <= '0;
      map_sel_r     <= 1'b0;
      signed_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCROLL_Y:   scroll_y_r    <= cfg_data;
        CFG_SCROLL_X:   scroll_x_r    <= cfg_data;
        CFG_MAP_SELECT: map_sel_r     <= cfg_data[0];
        CFG_SIGNED:     signed_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + VMEM_AW'(1);
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign fx = col_r + 8'(fill_r) + scroll_x_r;
  assign fy = 8'(row_r) + scroll_y_r;

  always_comb begin
    phase_nxt  = phase_r;
    dot_nxt    = dot_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    step_nxt   = step_r;
    fill_mid   = fill_r;
    fill_nxt   = fill_r;
    rowoff_nxt = rowoff_r;
    rd_addr    = {MAP_PREFIX, map_sel_r, fy[7:3], fx[7:3]};
    s1_nxt     = '0;
    s1_nxt.rd  = RD_NONE;
    if (in_command == CMD_TICK) begin
      dot_nxt = dot_r + 9'd1;
      case (phase_r)
        PH_SEARCH: begin
          if (dot_nxt >= SEARCH_TICKS) begin
            col_nxt   = '0;
            fill_nxt  = '0;
            step_nxt  = '0;
            phase_nxt = PH_TRANSFER;
          end
        end
        PH_TRANSFER: begin
          case (step_r) inside
            STEP_LOCATE: begin
              s1_nxt.rd  = RD_LOCATE;
              rowoff_nxt = {fy[2:0], 1'b0};
              step_nxt   = step_r + 3'd1;
            end
            STEP_PLANE_LO: begin
              s1_nxt.rd = RD_LO;
              rd_addr   = tile_base_r + VMEM_AW'(rowoff_r);
              step_nxt  = step_r + 3'd1;
            end
            STEP_PLANE_HI: begin
              s1_nxt.rd = RD_HI;
              rd_addr   = tile_base_r + VMEM_AW'(rowoff_r) + VMEM_AW'(1);
              step_nxt  = step_r + 3'd1;
            end
            default: begin
              if (step_r < STEP_PUSH) begin
                step_nxt = step_r + 3'd1;
              end else if (fill_r == '0) begin
                s1_nxt.push = 1'b1;
                fill_mid    = QUEUE_SLOTS;
                step_nxt    = '0;
              end
            end
          endcase
          fill_nxt = fill_mid;
          if (fill_mid != '0) begin
            fill_nxt       = fill_mid - 4'd1;
            s1_nxt.pix     = 1'b1;
            s1_nxt.pop_idx = 3'(fill_mid - 4'd1);
            s1_nxt.px      = col_r;
            s1_nxt.py      = 8'(row_r);
            col_nxt        = col_r + 8'd1;
            if (col_nxt >= VisWidth) begin
              phase_nxt = PH_HBLANK;
            end
          end
        end
        PH_HBLANK: begin
          if (dot_nxt >= LINE_TICKS) begin
            row_nxt   = row_r + RowW'(1);
            dot_nxt   = '0;
            phase_nxt = (row_nxt >= VisRows) ? PH_VBLANK : PH_SEARCH;
          end
        end
        PH_VBLANK: begin
          if (dot_nxt >= LINE_TICKS) begin
            row_nxt = row_r + RowW'(1);
            dot_nxt = '0;
            if (row_nxt >= EndRows) begin
              row_nxt   = '0;
              phase_nxt = PH_SEARCH;
            end
          end
        end
        default: phase_nxt = PH_SEARCH;
      endcase
    end
    s1_nxt.phase = phase_code(phase_nxt);
    s1_nxt.row   = 8'(row_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      dot_r    <= '0;
      row_r    <= '0;
      col_r    <= '0;
      step_r   <= '0;
      fill_r   <= '0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      dot_r    <= dot_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      step_r   <= step_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rowoff_r <= rowoff_nxt;
      s1_r     <= s1_nxt;
    end
  end

  assign ram_we    = clr_active_r || (in_accept && in_command == CMD_WRITE);
  assign ram_waddr = clr_active_r ? clr_addr_r : in_write_address;
  assign ram_wdata = clr_active_r ? 8'd0 : in_write_data;
  assign ram_re    = in_accept && s1_nxt.rd != RD_NONE;

  sbpf_ram #(
    .WIDTH (8),
    .DEPTH (VIDEO_MEM_BYTES)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign src_lo = s1_r.push ? plane_lo_r : q_lo_r;
  assign src_hi = s1_r.push ? plane_hi_r : q_hi_r;
  assign color  = s1_r.pix ? {src_hi[s1_r.pop_idx], src_lo[s1_r.pop_idx]} : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      case (s1_r.rd)
        RD_LOCATE: begin
          if (signed_mode_r) begin
            tile_base_r <= SIGNED_TILE_BASE + {1'b0, ram_rdata ^ TILE_INDEX_FLIP, 4'd0};
          end else begin
            tile_base_r <= {1'b0, ram_rdata, 4'd0};
          end
        end
        RD_LO:   plane_lo_r <= ram_rdata;
        RD_HI:   plane_hi_r <= ram_rdata;
        default: ;
      endcase
      if (s1_r.push) begin
        q_lo_r <= plane_lo_r;
        q_hi_r <= plane_hi_r;
      end
      out_pixel_valid <= s1_r.pix;
      out_pixel_x     <= s1_r.px;
      out_pixel_y     <= s1_r.py;
      out_color_id    <= color;
      out_phase       <= s1_r.phase;
      out_current_row <= s1_r.row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign push_in_s1   = s1_valid_r && s1_r.push;
  assign pix_out      = out_valid && out_pixel_valid;
  assign pix_phase_ok = out_phase == PHC_TRANSFER || out_phase == PHC_HBLANK;

  `SBPF_ASSERT_IMPL(a_clear_blocks_input, clk, rst_n, clr_active_r, !in_ready, "input in clear")
  `SBPF_ASSERT(a_fill_bound, clk, rst_n, fill_r <= QUEUE_SLOTS, "pixel queue fill out of range")
  `SBPF_ASSERT_IMPL(a_push_left, clk, rst_n, push_in_s1, s1_r.pix && s1_r.pop_idx == 3'd7, "push")
  `SBPF_ASSERT_IMPL(a_pixel_phase, clk, rst_n, pix_out, pix_phase_ok, "pixel outside transfer")

endmodule

`default_nettype wire

>>> sim/tb_scanline_background_pixel_fetcher.sv
`timescale 1ns / 100ps

module tb_scanline_background_pixel_fetcher;
  import sbpf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [1:0] color_id;
    logic [1:0] phase;
    logic [7:0] current_row;
  } pixel_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = CMD_TICK;
  logic [VMEM_AW-1:0]   in_write_address = '0;
  logic [7:0]           in_write_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_pixel_valid;
  logic [7:0]           out_pixel_x;
  logic [7:0]           out_pixel_y;
  logic [1:0]           out_color_id;
  logic [1:0]           out_phase;
  logic [7:0]           out_current_row;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCROLL_Y;
  logic [7:0]           cfg_data = '0;

  // Shadow of the pixel pipeline, advanced once per accepted input beat.
  logic [7:0]         vram_model [0:VIDEO_MEM_BYTES-1];
  logic [1:0]         lcd_phase;
  logic [8:0]         line_dot;
  logic [7:0]         line_row;
  logic [7:0]         draw_col;
  logic [2:0]         fetch_step;
  logic [VMEM_AW-1:0] tile_addr_base;
  logic [3:0]         tile_row_ofs;
  logic [7:0]         plane_lo;
  logic [7:0]         plane_hi;
  logic [1:0]         shifter [0:7];
  logic [3:0]         shifter_fill;
  logic [7:0]         scroll_y_q;
  logic [7:0]         scroll_x_q;
  logic               map_sel_q;
  logic               signed_idx_q;

  logic [7:0]  hot_tiles [0:5];
  pixel_beat_t pending_pixels [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          pixel_count = 0;
  bit          jitter_on = 1'b1;

  scanline_background_pixel_fetcher uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_write_address (in_write_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_valid  (out_pixel_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_color_id     (out_color_id),
    .out_phase        (out_phase),
    .out_current_row  (out_current_row),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (jitter_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic pixel_beat_t scanline_step(input logic cmd,
                                                input logic [VMEM_AW-1:0] addr,
                                                input logic [7:0] data);
    pixel_beat_t beat;
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [7:0]  idx;
    beat = '0;
    if (cmd == CMD_WRITE) begin
      vram_model[addr] = data;
    end else begin
      line_dot = line_dot + 9'd1;
      case (lcd_phase)
        PHC_SEARCH: begin
          if (line_dot >= SEARCH_TICKS) begin
            draw_col = '0;
            shifter_fill = '0;
            fetch_step = '0;
            lcd_phase = PHC_TRANSFER;
          end
        end
        PHC_TRANSFER: begin
          if (fetch_step == STEP_PUSH) begin
            if (shifter_fill == 0) begin
              for (int j = 0; j < 8; j++) shifter[j] = {plane_hi[j], plane_lo[j]};
              shifter_fill = QUEUE_SLOTS;
              fetch_step = '0;
            end
          end else begin
            case (fetch_step)
              STEP_LOCATE: begin
                fx = draw_col + {4'b0, shifter_fill} + scroll_x_q;
                fy = line_row + scroll_y_q;
                idx = vram_model[{MAP_PREFIX, map_sel_q, fy[7:3], fx[7:3]}];
                tile_addr_base = signed_idx_q ?
                                 SIGNED_TILE_BASE + {1'b0, idx ^ TILE_INDEX_FLIP, 4'b0} :
                                 {1'b0, idx, 4'b0};
                tile_row_ofs = {fy[2:0], 1'b0};
              end
              STEP_PLANE_LO:
                plane_lo = vram_model[tile_addr_base + VMEM_AW'(tile_row_ofs)];
              STEP_PLANE_HI:
                plane_hi = vram_model[tile_addr_base + VMEM_AW'(tile_row_ofs) + VMEM_AW'(1)];
              default: ;
            endcase
            fetch_step = fetch_step + 3'd1;
          end
          if (shifter_fill != 0) begin
            shifter_fill = shifter_fill - 4'd1;
            beat.pixel_valid = 1'b1;
            beat.pixel_x = draw_col;
            beat.pixel_y = line_row;
            beat.color_id = shifter[shifter_fill[2:0]];
            pixel_count++;
            draw_col = draw_col + 8'd1;
            if (draw_col >= DEF_VISIBLE_WIDTH) lcd_phase = PHC_HBLANK;
          end
        end
        default: begin
          if (line_dot >= LINE_TICKS) begin
            line_row = line_row + 8'd1;
            line_dot = '0;
            if (lcd_phase == PHC_HBLANK) begin
              lcd_phase = (line_row >= DEF_VISIBLE_ROWS) ? PHC_VBLANK : PHC_SEARCH;
            end else if (line_row >= DEF_VISIBLE_ROWS + VBLANK_ROWS) begin
              line_row = '0;
              lcd_phase = PHC_SEARCH;
            end
          end
        end
      endcase
    end
    beat.phase = lcd_phase;
    beat.current_row = line_row;
    return beat;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    pixel_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual row %0d",
                 $time, out_current_row);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("pixel_valid", 8'(want.pixel_valid), 8'(out_pixel_valid));
        compare_field("pixel_x", want.pixel_x, out_pixel_x);
        compare_field("pixel_y", want.pixel_y, out_pixel_y);
        compare_field("color_id", 8'(want.color_id), 8'(out_color_id));
        compare_field("phase", 8'(want.phase), 8'(out_phase));
        compare_field("current_row", want.current_row, out_current_row);
      end
    end
  end

  task automatic push_beat(input logic cmd, input logic [VMEM_AW-1:0] addr,
                           input logic [7:0] data);
    if (jitter_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_write_address <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(scanline_step(cmd, addr, data));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SCROLL_Y:   scroll_y_q = val;
      CFG_SCROLL_X:   scroll_x_q = val;
      CFG_MAP_SELECT: map_sel_q = val[0];
      CFG_SIGNED:     signed_idx_q = val[0];
      default: ;
    endcase
  endtask

  // The single-bit registers get random upper bits, which the block must ignore.
  task automatic retune(input logic [7:0] sy, input logic [7:0] sx,
                        input logic map_sel, input logic signed_idx);
    logic [31:0] rnd;
    rnd = $urandom;
    wait_drained();
    write_reg(CFG_SCROLL_Y, sy);
    write_reg(CFG_SCROLL_X, sx);
    write_reg(CFG_MAP_SELECT, {rnd[6:0], map_sel});
    write_reg(CFG_SIGNED, {rnd[14:8], signed_idx});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_scroll();
    logic [31:0] rnd;
    rnd = $urandom;
    case (rnd[31:30])
      2'd0:    return 8'h00;
      2'd1:    return 8'hFF;
      default: return rnd[7:0];
    endcase
  endfunction

  // Writes mostly land in the tile maps and in the bit planes of a few tiles, so that
  // the rendered lines carry nonzero and varied color IDs.
  task automatic traffic_beat(input int write_pct);
    logic [31:0]        rnd;
    logic [7:0]         idx;
    logic [VMEM_AW-1:0] base;
    int                 kind;
    rnd = $urandom;
    if ($urandom_range(0, 99) >= write_pct) begin
      push_beat(CMD_TICK, rnd[VMEM_AW-1:0], rnd[31:24]);
    end else begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        idx = ($urandom_range(0, 4) == 0) ? rnd[23:16] : hot_tiles[$urandom_range(0, 5)];
        push_beat(CMD_WRITE, {MAP_PREFIX, rnd[10:0]}, idx);
      end else if (kind < 9) begin
        idx = hot_tiles[$urandom_range(0, 5)];
        base = rnd[12] ? {1'b0, idx, 4'b0} :
               SIGNED_TILE_BASE + {1'b0, idx ^ TILE_INDEX_FLIP, 4'b0};
        push_beat(CMD_WRITE, base + VMEM_AW'(rnd[3:0]), rnd[31:24]);
      end else begin
        push_beat(CMD_WRITE, rnd[VMEM_AW-1:0], rnd[31:24]);
      end
    end
  endtask

  task automatic run_pixels(input int count, input int write_pct);
    int start;
    start = pixel_count;
    while (pixel_count - start < count) traffic_beat(write_pct);
  endtask

  task automatic test_write_extremes();
    push_beat(CMD_WRITE, '0, 8'hFF);
    push_beat(CMD_WRITE, '1, 8'h00);
    push_beat(CMD_WRITE, 13'h1555, 8'hAA);
    push_beat(CMD_WRITE, 13'h0AAA, 8'h55);
    push_beat(CMD_WRITE, 13'h1800, 8'h80);
    push_beat(CMD_WRITE, 13'h1BFF, 8'hFF);
    push_beat(CMD_WRITE, 13'h1C00, 8'h7F);
    push_beat(CMD_WRITE, 13'h1FFF, 8'h80);
    push_beat(CMD_WRITE, 13'h17FE, 8'hC3);
    push_beat(CMD_WRITE, 13'h17FF, 8'h3C);
    push_beat(CMD_WRITE, 13'h0FFE, 8'h0F);
    push_beat(CMD_WRITE, 13'h0800, 8'hF0);
    push_beat(CMD_TICK, '1, 8'hFF);
    push_beat(CMD_TICK, '0, 8'h00);
    repeat (6) push_beat(CMD_TICK, 13'h0AAA, 8'h55);
  endtask

  task automatic test_scene_load();
    repeat (300) traffic_beat(90);
  endtask

  // Each setting draws 32 pixels, four tiles' worth.
  task automatic test_scroll_extremes();
    retune(8'h00, 8'h00, 1'b0, 1'b0);
    run_pixels(32, 10);
    retune(8'hFF, 8'hFF, 1'b1, 1'b1);
    run_pixels(32, 10);
    retune(8'h00, 8'hFF, 1'b1, 1'b0);
    run_pixels(32, 10);
    retune(8'hFF, 8'h00, 1'b0, 1'b1);
    run_pixels(32, 10);
    retune(pick_scroll(), pick_scroll(), 1'b1, 1'b1);
    run_pixels(32, 10);
  endtask

  task automatic test_random_traffic();
    repeat (3) begin
      retune(pick_scroll(), pick_scroll(), $urandom_range(0, 1) != 0,
             $urandom_range(0, 1) != 0);
      repeat (200) traffic_beat(15);
    end
  endtask

  // Runs with no idling on either side.
  task automatic test_full_rate();
    jitter_on = 1'b0;
    retune(pick_scroll(), pick_scroll(), $urandom_range(0, 1) != 0,
           $urandom_range(0, 1) != 0);
    repeat (300) traffic_beat(5);
  endtask

  initial begin
    for (int i = 0; i < VIDEO_MEM_BYTES; i++) vram_model[i] = '0;
    for (int i = 0; i < 8; i++) shifter[i] = '0;
    lcd_phase = PHC_SEARCH;
    line_dot = '0;
    line_row = '0;
    draw_col = '0;
    fetch_step = '0;
    tile_addr_base = '0;
    tile_row_ofs = '0;
    plane_lo = '0;
    plane_hi = '0;
    shifter_fill = '0;
    scroll_y_q = '0;
    scroll_x_q = '0;
    map_sel_q = 1'b0;
    signed_idx_q = 1'b0;
    hot_tiles[0] = 8'h00;
    hot_tiles[1] = 8'h7F;
    hot_tiles[2] = 8'h80;
    hot_tiles[3] = 8'hFF;
    hot_tiles[4] = pick_scroll();
    hot_tiles[5] = pick_scroll();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    retune(8'h00, 8'h00, 1'b0, 1'b0);

    test_write_extremes();
    test_scene_load();
    test_scroll_extremes();
    test_random_traffic();
    test_full_rate();

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
